// ----- src/indexed_min_heap_decrement_assert.svh -----
// ----------------------------------------------------------------------------
// Heap assertion macros
// Shared concurrent assertion forms for the heap block.
// ----------------------------------------------------------------------------
`ifndef INDEXED_MIN_HEAP_DECREMENT_ASSERT_SVH
`define INDEXED_MIN_HEAP_DECREMENT_ASSERT_SVH

// implication checked every cycle outside reset
`define IMH_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// next-cycle implication
`define IMH_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

// ----- src/imh_pkg.sv -----
// ----------------------------------------------------------------------------
// Heap package
// Types and constants shared by the heap block.
// ----------------------------------------------------------------------------
`default_nettype none
package imh_pkg;
   localparam int CAPACITY   = 1024;
   localparam int KEY_BITS   = 10;
   localparam int KEY_SPACE  = 1 << KEY_BITS;
   localparam int VALUE_BITS = 16;
   localparam int SLOT_BITS  = 10;
   localparam int COUNT_BITS = 11;

   localparam logic [1:0] FUNC_INSERT = 2'd0;
   localparam logic [1:0] FUNC_DEC    = 2'd1;
   localparam logic [1:0] FUNC_POP    = 2'd2;

   localparam logic [2:0] ST_OK      = 3'd0;
   localparam logic [2:0] ST_FULL    = 3'd1;
   localparam logic [2:0] ST_EMPTY   = 3'd2;
   localparam logic [2:0] ST_ABSENT  = 3'd3;
   localparam logic [2:0] ST_PRESENT = 3'd4;

   typedef struct packed {
      logic [1:0]            func;
      logic [KEY_BITS-1:0]   key;
      logic [VALUE_BITS-1:0] new_value;
   } req_type;

   typedef struct packed {
      logic [KEY_BITS-1:0]   out_key;
      logic [VALUE_BITS-1:0] out_value;
      logic [2:0]            status;
      logic [COUNT_BITS-1:0] entry_count;
   } rsp_type;

   typedef struct packed {
      logic [KEY_BITS-1:0]   key;
      logic [VALUE_BITS-1:0] value;
   } entry_type;

   // position table read/write bundle
   typedef struct packed {
      logic                  we;
      logic [KEY_BITS-1:0]   waddr;
      logic                  wpresent;
      logic [SLOT_BITS-1:0]  wslot;
      logic [KEY_BITS-1:0]   raddr;
   } pos_cmd_type;
endpackage
`default_nettype wire

// ----- src/imh_heap_ram.sv -----
// ----------------------------------------------------------------------------
// Heap entry store
// Single-port-write, registered-read memory of heap slots.
// ----------------------------------------------------------------------------
`default_nettype none
module imh_heap_ram import imh_pkg::*; (
   input  wire logic                 clock,
   input  wire logic                 we,
   input  wire logic [SLOT_BITS-1:0] waddr,
   input  wire entry_type            wdata,
   input  wire logic [SLOT_BITS-1:0] raddr,
   output entry_type                 rdata
);
   entry_type mem [CAPACITY];

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata <= mem[raddr];
   end
endmodule
`default_nettype wire

// ----- src/imh_pos_table.sv -----
// ----------------------------------------------------------------------------
// Key position table
// Slot and present bit per key in one memory, cleared by a pass after reset.
// ----------------------------------------------------------------------------
`default_nettype none
module imh_pos_table import imh_pkg::*; (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire pos_cmd_type         cmd,
   output logic                     busy,
   output logic                     rpresent,
   output logic [SLOT_BITS-1:0]     rslot
);
   logic [SLOT_BITS:0]  pos_mem [KEY_SPACE];
   logic                clr_busy_ff, clr_busy_in;
   logic [KEY_BITS-1:0] clr_addr_ff, clr_addr_in;
   logic                mem_we;
   logic [KEY_BITS-1:0] mem_waddr;
   logic [SLOT_BITS:0]  mem_wdata;
   logic [SLOT_BITS:0]  mem_rdata;

   always_comb begin
      clr_busy_in = clr_busy_ff;
      clr_addr_in = clr_addr_ff;
      if (clr_busy_ff) begin
         clr_addr_in = clr_addr_ff + KEY_BITS'(1);
         if (clr_addr_ff == '1) begin
            clr_busy_in = 1'b0;
         end
      end
   end

   assign mem_we    = clr_busy_ff | cmd.we;
   assign mem_waddr = clr_busy_ff ? clr_addr_ff : cmd.waddr;
   assign mem_wdata = clr_busy_ff ? '0 : {cmd.wpresent, cmd.wslot};

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_busy_ff <= 1'b1;
         clr_addr_ff <= '0;
      end else begin
         clr_busy_ff <= clr_busy_in;
         clr_addr_ff <= clr_addr_in;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         pos_mem[mem_waddr] <= mem_wdata;
      end
      mem_rdata <= pos_mem[cmd.raddr];
   end

   assign busy     = clr_busy_ff;
   assign rpresent = mem_rdata[SLOT_BITS];
   assign rslot    = mem_rdata[SLOT_BITS-1:0];
endmodule
`default_nettype wire

// ----- src/indexed_min_heap_decrement.sv -----
// ----------------------------------------------------------------------------
// Indexed min-heap with decrease-by-one
// Binary min-heap of (key, value) pairs with a key-indexed position table.
// ----------------------------------------------------------------------------
//  channel | dir | payload  | transfer
//  req     | in  | req_type | req_valid & req_ready
//  rsp     | out | rsp_type | rsp_valid & rsp_ready
//
//  One operation at a time. Insert writes the new entry at the end and sifts it
//  up; decrement lowers the value by one (a zero value stays) and sifts it up;
//  pop returns the root, moves the last entry to the root and sifts it down.
//  Errors and a no-op skip the heap and answer after the key lookup.
//  The heap memory (one read, one write per cycle) sets the pace.
//  Reset starts a clearing pass over all 1024 entries of the position table.
//  req_ready stays low during that pass and from transfer until the result is
//  taken; a stalled result holds it low until rsp_ready.
`default_nettype none
module indexed_min_heap_decrement import imh_pkg::*; (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    req_valid,
   output logic         req_ready,
   input  wire req_type req_data,
   output logic         rsp_valid,
   input  wire logic    rsp_ready,
   output rsp_type      rsp_data
);
`include "indexed_min_heap_decrement_assert.svh"

   typedef enum logic [15:0] {
      S_IDLE  = 16'h0001,
      S_LOOK  = 16'h0002,
      S_CHECK = 16'h0004,
      S_RD0   = 16'h0008,
      S_RD0W  = 16'h0010,
      S_UPRD  = 16'h0020,
      S_UPW   = 16'h0040,
      S_UPCMP = 16'h0080,
      S_UPSW  = 16'h0100,
      S_LAST  = 16'h0200,
      S_DNL   = 16'h0400,
      S_DNR   = 16'h0800,
      S_DNCMP = 16'h1000,
      S_DNSW  = 16'h2000,
      S_DNPOS = 16'h4000,
      S_DONE  = 16'h8000
   } state_type;

   state_type state_ff, state_in;
   req_type   req_ff, req_in;
   rsp_type   rsp_ff, rsp_in;
   logic [COUNT_BITS-1:0] count_ff, count_in;
   logic [SLOT_BITS-1:0]  idx_ff, idx_in;
   logic [SLOT_BITS-1:0]  pick_ff, pick_in;
   entry_type cur_ff, cur_in;
   entry_type oth_ff, oth_in;
   logic      has_r_ff, has_r_in;

   logic                 ram_we;
   logic [SLOT_BITS-1:0] ram_waddr, ram_raddr;
   entry_type            ram_wdata, ram_rdata;
   pos_cmd_type          pcmd;
   logic                 pos_busy;
   logic                 p_present;
   logic [SLOT_BITS-1:0] p_slot;

   logic [COUNT_BITS-1:0] left_w, right_w;
   logic [VALUE_BITS-1:0] cmp_a, cmp_b;
   logic                  less;

   imh_heap_ram u_ram (
      .clock(clock), .we(ram_we), .waddr(ram_waddr), .wdata(ram_wdata),
      .raddr(ram_raddr), .rdata(ram_rdata)
   );

   imh_pos_table u_pos (
      .clock(clock), .reset(reset), .cmd(pcmd), .busy(pos_busy),
      .rpresent(p_present), .rslot(p_slot)
   );

   assign req_ready = (state_ff == S_IDLE) && !pos_busy;
   assign rsp_valid = (state_ff == S_DONE);
   assign rsp_data  = rsp_ff;

   assign left_w  = {idx_ff, 1'b1};
   assign right_w = left_w + COUNT_BITS'(1);

   // shared compare unit
   always_comb begin
      cmp_a = oth_ff.value;
      cmp_b = cur_ff.value;
      case (state_ff)
         S_UPCMP: begin
            cmp_a = cur_ff.value;
            cmp_b = ram_rdata.value;
         end
         S_DNCMP: begin
            cmp_a = ram_rdata.value;
            cmp_b = oth_ff.value;
         end
         default: ;
      endcase
   end
   assign less = cmp_a < cmp_b;

   always_comb begin
      state_in  = state_ff;
      req_in    = req_ff;
      rsp_in    = rsp_ff;
      count_in  = count_ff;
      idx_in    = idx_ff;
      pick_in   = pick_ff;
      cur_in    = cur_ff;
      oth_in    = oth_ff;
      has_r_in  = has_r_ff;
      ram_we    = 1'b0;
      ram_waddr = idx_ff;
      ram_wdata = cur_ff;
      ram_raddr = idx_ff;
      pcmd      = '0;
      pcmd.raddr = req_ff.key;

      case (state_ff)
         S_IDLE: begin
            pcmd.raddr = req_data.key;
            if (req_valid && req_ready) begin
               req_in   = req_data;
               rsp_in   = '0;
               state_in = S_LOOK;
            end
         end
         S_LOOK: begin
            state_in = S_CHECK;
         end
         S_CHECK: begin
            rsp_in.entry_count = count_ff;
            state_in = S_DONE;
            case (req_ff.func)
               FUNC_INSERT: begin
                  if (p_present) begin
                     rsp_in.status = ST_PRESENT;
                  end else if (count_ff >= COUNT_BITS'(CAPACITY)) begin
                     rsp_in.status = ST_FULL;
                  end else begin
                     idx_in       = count_ff[SLOT_BITS-1:0];
                     cur_in.key   = req_ff.key;
                     cur_in.value = req_ff.new_value;
                     ram_we       = 1'b1;
                     ram_waddr    = count_ff[SLOT_BITS-1:0];
                     ram_wdata    = '{req_ff.key, req_ff.new_value};
                     pcmd.we      = 1'b1;
                     pcmd.waddr   = req_ff.key;
                     pcmd.wpresent = 1'b1;
                     pcmd.wslot   = count_ff[SLOT_BITS-1:0];
                     count_in     = count_ff + COUNT_BITS'(1);
                     rsp_in.entry_count = count_ff + COUNT_BITS'(1);
                     state_in     = S_UPRD;
                  end
               end
               FUNC_DEC: begin
                  if (!p_present) begin
                     rsp_in.status = ST_ABSENT;
                  end else begin
                     idx_in   = p_slot;
                     state_in = S_RD0;
                  end
               end
               FUNC_POP: begin
                  if (count_ff == '0) begin
                     rsp_in.status = ST_EMPTY;
                  end else begin
                     idx_in   = '0;
                     state_in = S_RD0;
                  end
               end
               default: ;
            endcase
         end
         S_RD0: begin
            state_in = S_RD0W;
         end
         S_RD0W: begin
            if (req_ff.func == FUNC_DEC) begin
               cur_in = ram_rdata;
               if (ram_rdata.value != '0) begin
                  cur_in.value = ram_rdata.value - VALUE_BITS'(1);
                  ram_we    = 1'b1;
                  ram_wdata = cur_in;
                  state_in  = S_UPRD;
               end else begin
                  state_in = S_DONE;
               end
            end else begin
               rsp_in.out_key   = ram_rdata.key;
               rsp_in.out_value = ram_rdata.value;
               pcmd.we    = 1'b1;
               pcmd.waddr = ram_rdata.key;
               count_in   = count_ff - COUNT_BITS'(1);
               rsp_in.entry_count = count_ff - COUNT_BITS'(1);
               if (count_ff == COUNT_BITS'(1)) begin
                  state_in = S_DONE;
               end else begin
                  ram_raddr = SLOT_BITS'(count_ff - COUNT_BITS'(1));
                  state_in  = S_LAST;
               end
            end
         end
         // sift up: idx/cur is the moving entry
         S_UPRD: begin
            if (idx_ff == '0) begin
               state_in = S_DONE;
            end else begin
               pick_in   = (idx_ff - SLOT_BITS'(1)) >> 1;
               ram_raddr = (idx_ff - SLOT_BITS'(1)) >> 1;
               state_in  = S_UPW;
            end
         end
         S_UPW: begin
            ram_raddr = pick_ff;
            state_in  = S_UPCMP;
         end
         S_UPCMP: begin
            oth_in = ram_rdata;
            if (less) begin
               ram_we    = 1'b1;
               ram_waddr = idx_ff;
               ram_wdata = ram_rdata;
               pcmd.we   = 1'b1;
               pcmd.waddr = ram_rdata.key;
               pcmd.wpresent = 1'b1;
               pcmd.wslot = idx_ff;
               state_in  = S_UPSW;
            end else begin
               state_in = S_DONE;
            end
         end
         S_UPSW: begin
            ram_we     = 1'b1;
            ram_waddr  = pick_ff;
            ram_wdata  = cur_ff;
            pcmd.we    = 1'b1;
            pcmd.waddr = cur_ff.key;
            pcmd.wpresent = 1'b1;
            pcmd.wslot = pick_ff;
            idx_in     = pick_ff;
            state_in   = S_UPRD;
         end
         S_LAST: begin
            cur_in     = ram_rdata;
            idx_in     = '0;
            ram_we     = 1'b1;
            ram_waddr  = '0;
            ram_wdata  = ram_rdata;
            pcmd.we    = 1'b1;
            pcmd.waddr = ram_rdata.key;
            pcmd.wpresent = 1'b1;
            pcmd.wslot = '0;
            state_in   = S_DNL;
         end
         // sift down: read left, then right, compare through the shared unit
         S_DNL: begin
            if (left_w >= count_ff) begin
               state_in = S_DONE;
            end else begin
               ram_raddr = left_w[SLOT_BITS-1:0];
               has_r_in  = right_w < count_ff;
               state_in  = S_DNR;
            end
         end
         S_DNR: begin
            ram_raddr = right_w[SLOT_BITS-1:0];
            state_in  = S_DNCMP;
            pick_in   = left_w[SLOT_BITS-1:0];
            oth_in    = ram_rdata;
         end
         S_DNCMP: begin
            if (has_r_ff && less) begin
               oth_in  = ram_rdata;
               pick_in = right_w[SLOT_BITS-1:0];
            end
            state_in = S_DNSW;
         end
         S_DNSW: begin
            if (less) begin
               ram_we     = 1'b1;
               ram_waddr  = idx_ff;
               ram_wdata  = oth_ff;
               pcmd.we    = 1'b1;
               pcmd.waddr = oth_ff.key;
               pcmd.wpresent = 1'b1;
               pcmd.wslot = idx_ff;
               state_in   = S_DNPOS;
            end else begin
               state_in = S_DONE;
            end
         end
         S_DNPOS: begin
            ram_we     = 1'b1;
            ram_waddr  = pick_ff;
            ram_wdata  = cur_ff;
            pcmd.we    = 1'b1;
            pcmd.waddr = cur_ff.key;
            pcmd.wpresent = 1'b1;
            pcmd.wslot = pick_ff;
            idx_in     = pick_ff;
            state_in   = S_DNL;
         end
         S_DONE: begin
            if (rsp_ready) begin
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         count_ff <= '0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      req_ff   <= req_in;
      rsp_ff   <= rsp_in;
      idx_ff   <= idx_in;
      pick_ff  <= pick_in;
      cur_ff   <= cur_in;
      oth_ff   <= oth_in;
      has_r_ff <= has_r_in;
   end

   `IMH_ASSERT_IMP(a_count_range, clock, reset, 1'b1, count_ff <= COUNT_BITS'(CAPACITY))
   `IMH_ASSERT_IMP(a_ready_rsp_excl, clock, reset, 1'b1, !(req_ready && rsp_valid))
   `IMH_ASSERT_NEXT(a_count_held_done, clock, reset, rsp_valid, $stable(count_ff))
   `IMH_ASSERT_IMP(a_rsp_count, clock, reset, rsp_valid,
      rsp_data.entry_count == count_ff)
endmodule
`default_nettype wire

// ----- tb/tb_indexed_min_heap_decrement.sv -----
// ----------------------------------------------------------------------------
// Heap block testbench
// Drives insert, decrement and pop operations through the request channel
// with random idling on both sides, predicts every result with a behavioral
// indexed heap and compares each response field by field, in order.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps
`default_nettype none
module tb_indexed_min_heap_decrement;
   import imh_pkg::*;

   localparam logic [1:0] FUNC_NOP = 2'd3;
   localparam int FILL_COUNT = 120;

   logic    clock;
   logic    reset;
   logic    req_valid;
   logic    req_ready;
   req_type req_data;
   logic    rsp_valid;
   logic    rsp_ready;
   rsp_type rsp_data;

   indexed_min_heap_decrement i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   // behavioral heap
   entry_type             heap_slots [CAPACITY];
   int                    slot_of_key [KEY_SPACE];
   logic                  key_in_heap [KEY_SPACE];
   int                    heap_count;

   rsp_type pending_rsp [$];
   int      mismatch_count;
   int      idle_pct;

   typedef struct {
      req_type req;
      bit      fixed;
      rsp_type rsp;
   } stim_row_type;

   stim_row_type directed_rows [$];

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   function automatic void swap_slots(int a, int b);
      entry_type t;
      t             = heap_slots[a];
      heap_slots[a] = heap_slots[b];
      heap_slots[b] = t;
      slot_of_key[heap_slots[a].key] = a;
      slot_of_key[heap_slots[b].key] = b;
   endfunction

   function automatic void move_up(int i);
      int parent;
      while (i > 0) begin
         parent = (i - 1) / 2;
         if (heap_slots[parent].value > heap_slots[i].value) begin
            swap_slots(i, parent);
            i = parent;
         end else begin
            break;
         end
      end
   endfunction

   function automatic void move_down();
      int i, lc, rc, pick;
      i = 0;
      forever begin
         lc = 2 * i + 1;
         rc = lc + 1;
         if (lc >= heap_count) break;
         pick = lc;
         if (rc < heap_count && heap_slots[rc].value < heap_slots[lc].value) pick = rc;
         if (heap_slots[pick].value < heap_slots[i].value) begin
            swap_slots(i, pick);
            i = pick;
         end else begin
            break;
         end
      end
   endfunction

   function automatic rsp_type heap_apply(req_type r);
      rsp_type o;
      int p;
      o = '0;
      o.status = ST_OK;
      case (r.func)
         FUNC_INSERT: begin
            if (key_in_heap[r.key]) begin
               o.status = ST_PRESENT;
            end else if (heap_count >= CAPACITY) begin
               o.status = ST_FULL;
            end else begin
               heap_slots[heap_count].key   = r.key;
               heap_slots[heap_count].value = r.new_value;
               slot_of_key[r.key] = heap_count;
               key_in_heap[r.key] = 1'b1;
               heap_count++;
               move_up(heap_count - 1);
            end
         end
         FUNC_DEC: begin
            if (!key_in_heap[r.key]) begin
               o.status = ST_ABSENT;
            end else begin
               p = slot_of_key[r.key];
               if (heap_slots[p].value > 0) begin
                  heap_slots[p].value--;
                  move_up(p);
               end
            end
         end
         FUNC_POP: begin
            if (heap_count == 0) begin
               o.status = ST_EMPTY;
            end else begin
               o.out_key   = heap_slots[0].key;
               o.out_value = heap_slots[0].value;
               key_in_heap[heap_slots[0].key] = 1'b0;
               heap_count--;
               if (heap_count > 0) begin
                  heap_slots[0] = heap_slots[heap_count];
                  slot_of_key[heap_slots[0].key] = 0;
                  move_down();
               end
            end
         end
         default: ;
      endcase
      o.entry_count = COUNT_BITS'(heap_count);
      return o;
   endfunction

   task automatic send_op(req_type r, bit fixed, rsp_type fixed_rsp);
      rsp_type predicted;
      if ($urandom_range(99) < idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
         while ($urandom_range(99) < idle_pct) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= r;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      predicted = heap_apply(r);
      if (fixed && predicted !== fixed_rsp) begin
         mismatch_count++;
         $display("ERROR: directed row disagrees with prediction exp=%h pred=%h",
                  fixed_rsp, predicted);
      end
      pending_rsp.push_back(fixed ? fixed_rsp : predicted);
   endtask

   // sender goes idle and waits for every outstanding response
   task automatic drain();
      req_valid <= 1'b0;
      while (pending_rsp.size() != 0) @(posedge clock);
   endtask

   function automatic req_type mk_req(logic [1:0] f, int k, int v);
      req_type r;
      r.func = f;
      r.key = KEY_BITS'(k);
      r.new_value = VALUE_BITS'(v);
      return r;
   endfunction

   function automatic rsp_type mk_rsp(int k, int v, logic [2:0] s, int c);
      rsp_type o;
      o.out_key = KEY_BITS'(k);
      o.out_value = VALUE_BITS'(v);
      o.status = s;
      o.entry_count = COUNT_BITS'(c);
      return o;
   endfunction

   function automatic void add_row(req_type r, bit fixed, rsp_type o);
      stim_row_type row;
      row.req = r;
      row.fixed = fixed;
      row.rsp = o;
      directed_rows.push_back(row);
   endfunction

   // response side: random stall and in-order checking
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (pending_rsp.size() == 0) begin
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display("ERROR: unexpected response %h", rsp_data);
            end else begin
               automatic rsp_type exp = pending_rsp.pop_front();
               if (rsp_data.out_key !== exp.out_key
                   || rsp_data.out_value !== exp.out_value
                   || rsp_data.status !== exp.status
                   || rsp_data.entry_count !== exp.entry_count) begin
                  mismatch_count++;
                  if (mismatch_count <= 10)
                     $display({"ERROR: key exp %0d got %0d, value exp %0d got %0d, ",
                               "status exp %0d got %0d, count exp %0d got %0d"},
                              exp.out_key, rsp_data.out_key,
                              exp.out_value, rsp_data.out_value,
                              exp.status, rsp_data.status,
                              exp.entry_count, rsp_data.entry_count);
               end
            end
         end
         rsp_ready <= ($urandom_range(99) >= idle_pct);
      end
   end

   initial begin
      #2000000;
      $display("Test completed with failures");
      $finish;
   end

   initial begin
      req_type r;
      int      kind, k, wait_cycles;
      mismatch_count = 0;
      heap_count = 0;
      idle_pct = 26;
      for (int i = 0; i < KEY_SPACE; i++) begin
         key_in_heap[i] = 1'b0;
         slot_of_key[i] = 0;
      end
      reset     = 1'b1;
      req_valid = 1'b0;
      req_data  = '0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      add_row(mk_req(FUNC_POP, 0, 0), 1, mk_rsp(0, 0, ST_EMPTY, 0));
      add_row(mk_req(FUNC_DEC, 5, 0), 1, mk_rsp(0, 0, ST_ABSENT, 0));
      add_row(mk_req(FUNC_NOP, 1023, 65535), 1, mk_rsp(0, 0, ST_OK, 0));
      add_row(mk_req(FUNC_INSERT, 1023, 65535), 1, mk_rsp(0, 0, ST_OK, 1));
      add_row(mk_req(FUNC_INSERT, 1023, 0), 1, mk_rsp(0, 0, ST_PRESENT, 1));
      add_row(mk_req(FUNC_INSERT, 0, 0), 1, mk_rsp(0, 0, ST_OK, 2));
      add_row(mk_req(FUNC_DEC, 0, 0), 1, mk_rsp(0, 0, ST_OK, 2));
      add_row(mk_req(FUNC_INSERT, 682, 21845), 0, '0);
      add_row(mk_req(FUNC_INSERT, 341, 43690), 0, '0);
      add_row(mk_req(FUNC_DEC, 1023, 0), 0, '0);
      add_row(mk_req(FUNC_INSERT, 7, 21845), 0, '0);
      add_row(mk_req(FUNC_POP, 0, 0), 1, mk_rsp(0, 0, ST_OK, 4));
      add_row(mk_req(FUNC_POP, 1023, 65535), 0, '0);
      add_row(mk_req(FUNC_POP, 0, 0), 0, '0);
      add_row(mk_req(FUNC_POP, 0, 0), 0, '0);
      add_row(mk_req(FUNC_POP, 0, 0), 0, '0);
      add_row(mk_req(FUNC_POP, 0, 0), 1, mk_rsp(0, 0, ST_EMPTY, 0));
      foreach (directed_rows[i])
         send_op(directed_rows[i].req, directed_rows[i].fixed, directed_rows[i].rsp);

      // fill without idling, present check, then decrement and drain partly
      idle_pct = 0;
      for (int i = 0; i < FILL_COUNT; i++)
         send_op(mk_req(FUNC_INSERT, i ^ 10'h2a5, $urandom_range(65535)), 0, '0);
      send_op(mk_req(FUNC_INSERT, 10'h2a5, 0), 1,
              mk_rsp(0, 0, ST_PRESENT, FILL_COUNT));
      drain();
      for (int i = 0; i < 20; i++)
         send_op(mk_req(FUNC_DEC, $urandom_range(1023), 0), 0, '0);
      for (int i = 0; i < 60; i++) send_op(mk_req(FUNC_POP, 0, 0), 0, '0);

      // sender holds off until all responses are in
      drain();
      idle_pct = 26;

      for (int n = 0; n < 180; n++) begin
         if (n == 60) idle_pct = 0;
         if (n == 120) idle_pct = 26;
         kind = $urandom_range(99);
         k = (heap_count > 0 && $urandom_range(1))
             ? int'(heap_slots[$urandom_range(heap_count - 1)].key)
             : $urandom_range(1023);
         if (kind < 40)
            r = mk_req(FUNC_INSERT, $urandom_range(1023),
                       $urandom_range(1) ? $urandom_range(65535) : $urandom_range(20));
         else if (kind < 70)
            r = mk_req(FUNC_DEC, k, $urandom_range(65535));
         else if (kind < 97)
            r = mk_req(FUNC_POP, $urandom_range(1023), $urandom_range(65535));
         else
            r = mk_req(FUNC_NOP, $urandom_range(1023), $urandom_range(65535));
         send_op(r, 0, '0);
      end

      req_valid <= 1'b0;
      wait_cycles = 0;
      while (pending_rsp.size() != 0 && wait_cycles < 100000) begin
         @(posedge clock);
         wait_cycles++;
      end
      repeat (100) @(posedge clock);
      if (mismatch_count == 0 && pending_rsp.size() == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end
endmodule
`default_nettype wire

// ----- indexed_min_heap_decrement.f -----
+incdir+src
src/imh_pkg.sv
src/imh_heap_ram.sv
src/imh_pos_table.sv
src/indexed_min_heap_decrement.sv
tb/tb_indexed_min_heap_decrement.sv
